// ----- sv/tsol_pkg.sv -----
// Shared types and codes for the transpose self-organising list.
// No dependencies; imported by tsol_ctrl, tsol_dp and the top level.
package tsol_pkg;

  // Command field codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Which result the datapath registers this cycle
  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_APPEND  = 3'd1,
    RES_FULL    = 3'd2,
    RES_MISS    = 3'd3,
    RES_HIT0    = 3'd4,
    RES_HITSWAP = 3'd5
  } res_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     append_wr;  // write value at the fill index, bump fill count
    logic     load_key;   // latch key, clear index, read entry zero
    logic     scan_step;  // keep current entry as previous, advance, read next
    logic     wr_prev;    // write previous entry at the current index
    logic     wr_key;     // write key one place before the current index
    res_sel_e res;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_head;
    logic at_last;
  } stat_t;

  localparam int unsigned POS_W = 7;

endpackage

// ----- sv/tsol_ctrl.sv -----
// Controller state machine for the transpose self-organising list.
// Depends on tsol_pkg; drives tsol_dp through cmd_t and reads stat_t.
module tsol_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            command_i,
  input  tsol_pkg::stat_t stat_i,
  output tsol_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import tsol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SWAP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.append_wr = 1'b0;
    cmd_o.load_key  = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.wr_prev   = 1'b0;
    cmd_o.wr_key    = 1'b0;
    cmd_o.res       = RES_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_APPEND) begin
            if (stat_i.full) begin
              cmd_o.res = RES_FULL;
            end else begin
              cmd_o.append_wr = 1'b1;
              cmd_o.res       = RES_APPEND;
            end
          end else if (stat_i.empty) begin
            cmd_o.res = RES_MISS;
          end else begin
            cmd_o.load_key = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.match) begin
          if (stat_i.at_head) begin
            cmd_o.res = RES_HIT0;
            state_d   = S_IDLE;
          end else begin
            cmd_o.wr_prev = 1'b1;
            state_d       = S_SWAP;
          end
        end else if (stat_i.at_last) begin
          cmd_o.res = RES_MISS;
          state_d   = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SWAP: begin
        cmd_o.wr_key = 1'b1;
        cmd_o.res    = RES_HITSWAP;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- sv/tsol_dp.sv -----
// Datapath for the transpose self-organising list: entry memory, fill count,
// scan index, key and result registers. Depends on tsol_pkg.
module tsol_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsol_pkg::cmd_t                cmd_i,
  input  logic signed [31:0]            value_i,
  output tsol_pkg::stat_t               stat_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [tsol_pkg::POS_W-1:0]    position_o
);
  import tsol_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];

  logic signed [31:0] key_q, prev_q, rd_data_q;
  logic [AW-1:0]      idx_q;
  logic [FW-1:0]      fill_q;
  logic               done_q;
  status_e            status_q;
  logic [POS_W-1:0]   position_q;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] wr_data;

  always_comb begin
    wr_en   = cmd_i.append_wr | cmd_i.wr_prev | cmd_i.wr_key;
    wr_addr = idx_q;
    wr_data = prev_q;
    if (cmd_i.append_wr) begin
      wr_addr = fill_q[AW-1:0];
      wr_data = value_i;
    end else if (cmd_i.wr_key) begin
      wr_addr = idx_q - AW'(1);
      wr_data = key_q;
    end
    rd_en   = cmd_i.load_key | cmd_i.scan_step;
    rd_addr = cmd_i.load_key ? '0 : idx_q + AW'(1);
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= value_i;
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      prev_q <= rd_data_q;
      idx_q  <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.append_wr) begin
        fill_q <= fill_q + FW'(1);
      end
      done_q <= (cmd_i.res != RES_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res)
      RES_APPEND: begin
        status_q   <= ST_OK;
        position_q <= POS_W'(fill_q);
      end
      RES_FULL: begin
        status_q   <= ST_FULL;
        position_q <= '0;
      end
      RES_MISS: begin
        status_q   <= ST_MISS;
        position_q <= '0;
      end
      RES_HIT0: begin
        status_q   <= ST_OK;
        position_q <= '0;
      end
      RES_HITSWAP: begin
        status_q   <= ST_OK;
        position_q <= POS_W'(idx_q - AW'(1));
      end
      default: begin
        status_q   <= status_q;
        position_q <= position_q;
      end
    endcase
  end

  assign stat_o.full    = (fill_q == FW'(CAPACITY));
  assign stat_o.empty   = (fill_q == '0);
  assign stat_o.match   = (rd_data_q == key_q);
  assign stat_o.at_head = (idx_q == '0);
  assign stat_o.at_last = ((FW'(idx_q) + FW'(1)) == fill_q);

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign position_o = position_q;

endmodule

// ----- sv/transpose_self_organizing_list.sv -----
// Top level of the transpose self-organising list.
// Depends on tsol_pkg and instantiates tsol_ctrl and tsol_dp.
//
//   Channel   Handshake             Payload
//   -------   -------------------   -------------------------------
//   command   start_i, busy_o       command_i, value_i
//   result    done_o (strobe)       status_o, position_o
//
// Timing: an append, a refused append and a search on an empty table are
// taken from idle; the result strobes on the following cycle and busy_o stays
// low, so a new transaction may start at once. A search spends its accept
// cycle reading entry zero, then reads one entry per cycle from the single
// read port of the entry memory until it finds the key or compares the last
// entry below the fill count; a hit at a non-zero index then adds the second
// swap write, which writes the key one place before the hit index.
// Reset (rst_ni, asynchronous, active low) clears the fill count, the state
// machine and the strobe; the entry memory is never cleared, as only entries
// below the fill count are ever read. The receiver cannot stall: done_o pulses
// for exactly one cycle per transaction.
module transpose_self_organizing_list #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       command_i,
  input  logic signed [31:0]         value_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [tsol_pkg::POS_W-1:0] position_o
);
  import tsol_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  // Sequence the scan and the two-step swap
  tsol_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // Hold the table, the fill count and the result registers
  tsol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .stat_o     (stat),
    .done_o     (done_o),
    .status_o   (status_o),
    .position_o (position_o)
  );

  assign busy_o = busy;

endmodule
